>>> design/sha1he_pkg.sv
// sha1he_pkg: shared types, constants and codes of the SHA-1 hash engine.
// Used by sha1he_sched_mem and sha1_hash_engine_unit. No dependencies.
package sha1he_pkg;

    // Round constants
    localparam logic [31:0] K_R0 = 32'h5a827999;
    localparam logic [31:0] K_R1 = 32'h6ed9eba1;
    localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_R3 = 32'hca62c1d6;

    // Initial chaining value, H_INIT[0] is H0
    localparam logic [4:0][31:0] H_INIT = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [6:0] SCHED_WORDS = 7'd16;
    localparam logic [2:0] LAST_WORD  = 3'd4;
    localparam logic [3:0] LEN_HI_IDX = 4'd14;
    localparam logic [3:0] LEN_LO_IDX = 4'd15;

    // func codes
    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_RND_A,
        ST_RND_B,
        ST_RND_LAST,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } msg_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } dig_t;

    // Schedule memory write request
    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [31:0] data;
    } mem_wr_t;

    // Schedule memory read addresses, both ports
    typedef struct packed {
        logic [3:0] addr0;
        logic [3:0] addr1;
    } mem_rd_t;

endpackage

>>> design/sha1he_sched_mem.sv
// sha1he_sched_mem: 16 x 32 block buffer / message schedule store.
// One write port, two read ports, registered read data. Uses sha1he_pkg.
module sha1he_sched_mem (
    input  logic                 clk,
    input  sha1he_pkg::mem_wr_t  wr,
    input  sha1he_pkg::mem_rd_t  rd,
    output logic [31:0]          rd_data0,
    output logic [31:0]          rd_data1
);
    import sha1he_pkg::*;

    logic [31:0] mem [16];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data0 <= mem[rd.addr0];
        rd_data1 <= mem[rd.addr1];
    end

endmodule

>>> design/sha1_hash_engine_unit.sv
// sha1_hash_engine_unit: SHA-1 engine top level, byte input, digest word output.
// Depends on sha1he_pkg and sha1he_sched_mem.
//
// Usage
//   msg channel (msg_valid / msg_ready / msg): one transfer per item.
//     func = absorb appends msg.data_byte to the 64-byte block buffer.
//     func = finish pads the message, appends the 64-bit bit count and
//     closes it; five digest transfers then follow on the dig channel.
//   dig channel (dig_valid / dig_ready / dig): digest words H0..H4 in
//     order, word_index 0..4, last set on the fifth word.
//   Compression: the 64th byte of a block starts a compression of 80 rounds,
//     each through ST_RND_A and ST_RND_B, then a drain step (ST_RND_LAST)
//     and the chaining add (ST_ADD). Each round needs four schedule words,
//     read over the two ports of the schedule memory in ST_RND_A and
//     ST_RND_B. No byte is taken while a compression runs.
//   A finish writes the pad word, then each remaining zero/length word
//     (up to 15) in ST_PAD before the rounds start, then one compression.
//     When 56 or more bytes sit in the buffer a second block follows:
//     sixteen zero/length words, then a second compression. Then the five
//     digest words.
//   msg_ready is high only while the engine is idle.
//   If the receiver stalls, the current digest word is held on dig until
//     taken; no new message item is accepted until the fifth word goes.
//   After the last digest transfer the engine is back in its initial
//   state. Reset (asynchronous, rst_n low) does the same; the schedule
//   memory is not cleared, as every word is written before it is read.
module sha1_hash_engine_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               msg_valid,
    output logic               msg_ready,
    input  sha1he_pkg::msg_t   msg,
    output logic               dig_valid,
    input  logic               dig_ready,
    output sha1he_pkg::dig_t   dig
);
    import sha1he_pkg::*;

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {v, v} << n;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20)
            k = K_R0;
        else if (t < 7'd40)
            k = K_R1;
        else if (t < 7'd60)
            k = K_R2;
        else
            k = K_R3;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20)
            f = (b & c) | (~b & d);
        else if (t < 7'd40)
            f = b ^ c ^ d;
        else if (t < 7'd60)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

    // State
    state_t           state_reg,   state_next;
    logic [6:0]       round_reg,   round_next;
    logic [4:0][31:0] work_reg,    work_next;    // a..e
    logic [4:0][31:0] hash_reg,    hash_next;
    logic [31:0]      xor_reg,     xor_next;     // first half of W(t) XOR
    logic [31:0]      ek_reg,      ek_next;      // e + K(t), added ahead
    logic [5:0]       byte_pos_reg, byte_pos_next;
    logic [63:0]      bit_len_reg, bit_len_next;
    logic [31:0]      asm_reg,     asm_next;     // word being assembled
    logic [4:0]       fill_reg,    fill_next;    // next word to pad
    logic             fin_reg,     fin_next;
    logic             extra_reg,   extra_next;   // length goes in a second block
    logic [2:0]       out_idx_reg, out_idx_next;

    // Schedule memory
    mem_wr_t          mem_wr;
    mem_rd_t          mem_rd;
    logic [31:0]      rd_data0;
    logic [31:0]      rd_data1;

    sha1he_sched_mem u_sched_mem (
        .clk      (clk),
        .wr       (mem_wr),
        .rd       (mem_rd),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    // Round completion, byte assembly and pad word datapath
    logic [6:0]  tc;
    logic [31:0] w_new;
    logic [31:0] t_sum;
    logic [1:0]  lane;
    logic [4:0]  lane_sh;
    logic [31:0] asm_ins;
    logic [31:0] pad_word;

    always_comb
    begin
        tc      = (state_reg == ST_RND_LAST) ? round_reg : round_reg - 7'd1;
        w_new   = (tc < SCHED_WORDS) ? xor_reg : rotl(xor_reg ^ rd_data0 ^ rd_data1, 5'd1);
        t_sum   = rotl(work_reg[0], 5'd5)
                + round_f(tc, work_reg[1], work_reg[2], work_reg[3])
                + ek_reg + w_new;
        lane    = byte_pos_reg[1:0];
        lane_sh = {~lane, 3'b000};
        asm_ins = (asm_reg & ~(32'h000000ff << lane_sh))
                | ({24'd0, msg.data_byte} << lane_sh);
        pad_word = (asm_reg & ~(32'hffffffff >> {lane, 3'b000}))
                 | ({PAD_BYTE, 24'd0} >> {lane, 3'b000});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            round_reg    <= '0;
            work_reg     <= '0;
            hash_reg     <= H_INIT;
            byte_pos_reg <= '0;
            bit_len_reg  <= '0;
            fill_reg     <= '0;
            fin_reg      <= 1'b0;
            extra_reg    <= 1'b0;
            out_idx_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            work_reg     <= work_next;
            hash_reg     <= hash_next;
            byte_pos_reg <= byte_pos_next;
            bit_len_reg  <= bit_len_next;
            fill_reg     <= fill_next;
            fin_reg      <= fin_next;
            extra_reg    <= extra_next;
            out_idx_reg  <= out_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xor_reg <= xor_next;
        ek_reg  <= ek_next;
        asm_reg <= asm_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        round_next    = round_reg;
        work_next     = work_reg;
        hash_next     = hash_reg;
        xor_next      = xor_reg;
        ek_next       = ek_reg;
        byte_pos_next = byte_pos_reg;
        bit_len_next  = bit_len_reg;
        asm_next      = asm_reg;
        fill_next     = fill_reg;
        fin_next      = fin_reg;
        extra_next    = extra_reg;
        out_idx_next  = out_idx_reg;
        mem_wr        = '0;
        mem_rd        = '0;
        msg_ready     = 1'b0;
        dig_valid     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                msg_ready = 1'b1;
                if (msg_valid)
                begin
                    if (msg.func == FUNC_ABSORB)
                    begin
                        asm_next      = asm_ins;
                        byte_pos_next = byte_pos_reg + 6'd1;
                        bit_len_next  = bit_len_reg + 64'd8;
                        if (lane == 2'd3)
                        begin
                            mem_wr.en   = 1'b1;
                            mem_wr.addr = byte_pos_reg[5:2];
                            mem_wr.data = asm_ins;
                        end
                        if (byte_pos_reg == 6'd63)
                        begin
                            work_next  = hash_reg;
                            round_next = '0;
                            state_next = ST_RND_A;
                        end
                    end
                    else
                    begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = byte_pos_reg[5:2];
                        mem_wr.data = pad_word;
                        fill_next   = {1'b0, byte_pos_reg[5:2]} + 5'd1;
                        extra_next  = (byte_pos_reg[5:3] == 3'b111);
                        fin_next    = 1'b1;
                        state_next  = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                if (fill_reg[4])
                begin
                    work_next  = hash_reg;
                    round_next = '0;
                    state_next = ST_RND_A;
                end
                else
                begin
                    mem_wr.en   = 1'b1;
                    mem_wr.addr = fill_reg[3:0];
                    if (!extra_reg && fill_reg[3:0] == LEN_HI_IDX)
                        mem_wr.data = bit_len_reg[63:32];
                    else if (!extra_reg && fill_reg[3:0] == LEN_LO_IDX)
                        mem_wr.data = bit_len_reg[31:0];
                    else
                        mem_wr.data = '0;
                    fill_next = fill_reg + 5'd1;
                end
            end

            ST_RND_A:
            begin
                // W(t-3), W(t-8); finish the previous round
                mem_rd.addr0 = (round_reg < SCHED_WORDS) ? round_reg[3:0]
                                                        : round_reg[3:0] + 4'd13;
                mem_rd.addr1 = round_reg[3:0] + 4'd8;
                if (round_reg != '0)
                begin
                    work_next = {work_reg[3], work_reg[2], rotl(work_reg[1], 5'd30),
                                 work_reg[0], t_sum};
                    if (tc >= SCHED_WORDS)
                    begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = tc[3:0];
                        mem_wr.data = w_new;
                    end
                end
                state_next = ST_RND_B;
            end

            ST_RND_B:
            begin
                // W(t-14), W(t-16)
                mem_rd.addr0 = round_reg[3:0] + 4'd2;
                mem_rd.addr1 = round_reg[3:0];
                xor_next = (round_reg < SCHED_WORDS) ? rd_data0 : rd_data0 ^ rd_data1;
                ek_next  = work_reg[4] + round_k(round_reg);
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_RND_LAST;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                    state_next = ST_RND_A;
                end
            end

            ST_RND_LAST:
            begin
                work_next = {work_reg[3], work_reg[2], rotl(work_reg[1], 5'd30),
                             work_reg[0], t_sum};
                mem_wr.en   = 1'b1;
                mem_wr.addr = tc[3:0];
                mem_wr.data = w_new;
                round_next  = '0;
                state_next  = ST_ADD;
            end

            ST_ADD:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    hash_next[i] = hash_reg[i] + work_reg[i];
                end
                if (extra_reg)
                begin
                    extra_next = 1'b0;
                    fill_next  = '0;
                    state_next = ST_PAD;
                end
                else if (fin_reg)
                begin
                    out_idx_next = '0;
                    state_next   = ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_OUT:
            begin
                dig_valid = 1'b1;
                if (dig_ready)
                begin
                    if (out_idx_reg == LAST_WORD)
                    begin
                        hash_next     = H_INIT;
                        work_next     = '0;
                        bit_len_next  = '0;
                        byte_pos_next = '0;
                        fin_next      = 1'b0;
                        out_idx_next  = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Digest output
    always_comb
    begin
        case (out_idx_reg)
            3'd0:    dig.digest_word = hash_reg[0];
            3'd1:    dig.digest_word = hash_reg[1];
            3'd2:    dig.digest_word = hash_reg[2];
            3'd3:    dig.digest_word = hash_reg[3];
            default: dig.digest_word = hash_reg[4];
        endcase
        dig.word_index = out_idx_reg;
        dig.last       = (out_idx_reg == LAST_WORD);
    end

    // Checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(msg_ready && dig_valid))
        else $error("msg and dig channels active together");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= LAST_ROUND)
        else $error("round counter out of range");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_idx_reg <= LAST_WORD)
        else $error("digest word index out of range");

    a_digest_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD && fin_reg && !extra_reg) |=> dig_valid)
        else $error("digest not presented after final block");

    a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid && dig_ready && dig.last) |=>
            (hash_reg == H_INIT && byte_pos_reg == '0 && bit_len_reg == '0 && msg_ready))
        else $error("engine not reinitialised after last digest word");

endmodule
